>>> rtl/obn_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package obn_pkg;

	localparam int IN_WIDTH  = 16;
	localparam int FRAC_BITS = 14;
	localparam int OUT_WIDTH = FRAC_BITS + 2;
	localparam int NUM_LANES = 9;

	// lane order of the root chains
	localparam int LANE_UX = 0;
	localparam int LANE_UY = 1;
	localparam int LANE_UZ = 2;
	localparam int LANE_VX = 3;
	localparam int LANE_VY = 4;
	localparam int LANE_VZ = 5;
	localparam int LANE_WX = 6;
	localparam int LANE_WY = 7;
	localparam int LANE_WZ = 8;

	localparam logic [1:0] AXIS_X = 2'd0;
	localparam logic [1:0] AXIS_Y = 2'd1;
	localparam logic [1:0] AXIS_Z = 2'd2;

	typedef struct packed {
		logic signed [IN_WIDTH-1:0] normal_x;
		logic signed [IN_WIDTH-1:0] normal_y;
		logic signed [IN_WIDTH-1:0] normal_z;
	} normal_t;

	typedef struct packed {
		logic signed [OUT_WIDTH-1:0] u_x;
		logic signed [OUT_WIDTH-1:0] u_y;
		logic signed [OUT_WIDTH-1:0] u_z;
		logic signed [OUT_WIDTH-1:0] v_x;
		logic signed [OUT_WIDTH-1:0] v_y;
		logic signed [OUT_WIDTH-1:0] v_z;
		logic signed [OUT_WIDTH-1:0] w_x;
		logic signed [OUT_WIDTH-1:0] w_y;
		logic signed [OUT_WIDTH-1:0] w_z;
		logic [1:0]                  major_axis;
		logic                        degenerate;
	} basis_t;

	// per-word side information travelling beside the root chains
	typedef struct packed {
		logic [NUM_LANES-1:0] neg;
		logic                 zero;
		logic [1:0]           axis;
	} sideband_t;

endpackage
`default_nettype wire

>>> rtl/obn_prep.sv
`timescale 1ns / 1ps
`default_nettype none
module obn_prep #(
	parameter int W  = obn_pkg::IN_WIDTH,
	parameter int PW = 4 * W,
	parameter int QW = 4 * W + 3
) (
	input  wire                 clk,
	input  wire  signed [W-1:0] in_x,
	input  wire  signed [W-1:0] in_y,
	input  wire  signed [W-1:0] in_z,
	output logic [PW-1:0]       p_s4 [obn_pkg::NUM_LANES],
	output logic [QW-1:0]       q_s4 [obn_pkg::NUM_LANES],
	output obn_pkg::sideband_t  sb_s4
);

	localparam int SW = 2 * W + 2;
	localparam int TW = 2 * W + 1;
	localparam int H  = W + 1;
	localparam int MW = 3 * W + 2;
	localparam int RW = 3 * W;

	// stage 1: magnitudes, major axis, squares and cross products
	logic [W-1:0] mx, my, mz, best;
	logic [1:0]   axis_c;
	logic [2*W-1:0] sq_s1 [3];
	logic [2*W-1:0] pxy_s1, pxz_s1, pyz_s1;
	logic [2:0]   sg_s1;
	logic         zero_s1;
	logic [1:0]   axis_s1;

	always_comb begin
		mx = in_x[W-1] ? (~in_x + 1'b1) : in_x;
		my = in_y[W-1] ? (~in_y + 1'b1) : in_y;
		mz = in_z[W-1] ? (~in_z + 1'b1) : in_z;
		axis_c = obn_pkg::AXIS_X;
		best   = mx;
		if (my > best) begin
			axis_c = obn_pkg::AXIS_Y;
			best   = my;
		end
		if (mz > best) begin
			axis_c = obn_pkg::AXIS_Z;
		end
	end

	always_ff @(posedge clk) begin
		sq_s1[0] <= mx * mx;
		sq_s1[1] <= my * my;
		sq_s1[2] <= mz * mz;
		pxy_s1   <= mx * my;
		pxz_s1   <= mx * mz;
		pyz_s1   <= my * mz;
		sg_s1    <= {in_z[W-1], in_y[W-1], in_x[W-1]};
		zero_s1  <= (mx == '0) && (my == '0) && (mz == '0);
		axis_s1  <= axis_c;
	end

	// stage 2: norms, choice of products, signs
	logic [SW-1:0]    s_s2;
	logic [TW-1:0]    t2_s2;
	logic [2*W-1:0]   pa_s2, pb_s2;
	logic [2*W-1:0]   sq_s2 [3];
	obn_pkg::sideband_t sb_c, sb_s2;

	always_comb begin
		sb_c.zero = zero_s1;
		sb_c.axis = axis_s1;
		sb_c.neg  = '0;
		sb_c.neg[obn_pkg::LANE_WX] = sg_s1[0];
		sb_c.neg[obn_pkg::LANE_WY] = sg_s1[1];
		sb_c.neg[obn_pkg::LANE_WZ] = sg_s1[2];
		if (axis_s1 != obn_pkg::AXIS_X) begin
			sb_c.neg[obn_pkg::LANE_UY] = (sg_s1[0] == sg_s1[1]);
			sb_c.neg[obn_pkg::LANE_UZ] = (sg_s1[0] == sg_s1[2]);
			sb_c.neg[obn_pkg::LANE_VY] = sg_s1[2];
			sb_c.neg[obn_pkg::LANE_VZ] = ~sg_s1[1];
		end else begin
			sb_c.neg[obn_pkg::LANE_UX] = (sg_s1[0] == sg_s1[1]);
			sb_c.neg[obn_pkg::LANE_UZ] = (sg_s1[1] == sg_s1[2]);
			sb_c.neg[obn_pkg::LANE_VX] = ~sg_s1[2];
			sb_c.neg[obn_pkg::LANE_VZ] = sg_s1[0];
		end
	end

	always_ff @(posedge clk) begin
		s_s2  <= SW'(sq_s1[0]) + SW'(sq_s1[1]) + SW'(sq_s1[2]);
		t2_s2 <= (axis_s1 != obn_pkg::AXIS_X) ? (TW'(sq_s1[1]) + TW'(sq_s1[2]))
		                                      : (TW'(sq_s1[0]) + TW'(sq_s1[2]));
		pa_s2 <= pxy_s1;
		pb_s2 <= (axis_s1 != obn_pkg::AXIS_X) ? pxz_s1 : pyz_s1;
		sq_s2 <= sq_s1;
		sb_s2 <= sb_c;
	end

	// stage 3: partial products of T^2*S and of the squared cross products
	logic [MW-1:0]  qlo_s3, qhi_s3;
	logic [RW-1:0]  palo_s3, pahi_s3, pblo_s3, pbhi_s3;
	logic [SW-1:0]  s_s3;
	logic [TW-1:0]  t2_s3;
	logic [2*W-1:0] sq_s3 [3];
	obn_pkg::sideband_t sb_s3;

	always_ff @(posedge clk) begin
		qlo_s3  <= t2_s2 * s_s2[H-1:0];
		qhi_s3  <= t2_s2 * s_s2[SW-1:H];
		palo_s3 <= pa_s2 * pa_s2[W-1:0];
		pahi_s3 <= pa_s2 * pa_s2[2*W-1:W];
		pblo_s3 <= pb_s2 * pb_s2[W-1:0];
		pbhi_s3 <= pb_s2 * pb_s2[2*W-1:W];
		s_s3    <= s_s2;
		t2_s3   <= t2_s2;
		sq_s3   <= sq_s2;
		sb_s3   <= sb_s2;
	end

	// stage 4: sum partials, route numerators and denominators to lanes
	logic [QW-1:0] qu, qs, qt;
	logic [PW-1:0] pua, pub, pt2;

	always_comb begin
		qu  = QW'(qlo_s3) + (QW'(qhi_s3) << H);
		qs  = QW'(s_s3);
		qt  = QW'(t2_s3);
		pua = PW'(palo_s3) + (PW'(pahi_s3) << W);
		pub = PW'(pblo_s3) + (PW'(pbhi_s3) << W);
		pt2 = PW'(t2_s3);
	end

	always_ff @(posedge clk) begin
		p_s4[obn_pkg::LANE_WX] <= PW'(sq_s3[0]);
		p_s4[obn_pkg::LANE_WY] <= PW'(sq_s3[1]);
		p_s4[obn_pkg::LANE_WZ] <= PW'(sq_s3[2]);
		q_s4[obn_pkg::LANE_WX] <= qs;
		q_s4[obn_pkg::LANE_WY] <= qs;
		q_s4[obn_pkg::LANE_WZ] <= qs;
		q_s4[obn_pkg::LANE_VX] <= qt;
		q_s4[obn_pkg::LANE_VY] <= qt;
		q_s4[obn_pkg::LANE_VZ] <= qt;
		q_s4[obn_pkg::LANE_UZ] <= qu;
		p_s4[obn_pkg::LANE_UZ] <= pub;
		if (sb_s3.axis != obn_pkg::AXIS_X) begin
			p_s4[obn_pkg::LANE_UX] <= pt2;
			q_s4[obn_pkg::LANE_UX] <= qs;
			p_s4[obn_pkg::LANE_UY] <= pua;
			q_s4[obn_pkg::LANE_UY] <= qu;
			p_s4[obn_pkg::LANE_VX] <= '0;
			p_s4[obn_pkg::LANE_VY] <= PW'(sq_s3[2]);
			p_s4[obn_pkg::LANE_VZ] <= PW'(sq_s3[1]);
		end else begin
			p_s4[obn_pkg::LANE_UX] <= pua;
			q_s4[obn_pkg::LANE_UX] <= qu;
			p_s4[obn_pkg::LANE_UY] <= pt2;
			q_s4[obn_pkg::LANE_UY] <= qs;
			p_s4[obn_pkg::LANE_VX] <= PW'(sq_s3[2]);
			p_s4[obn_pkg::LANE_VY] <= '0;
			p_s4[obn_pkg::LANE_VZ] <= PW'(sq_s3[0]);
		end
		sb_s4 <= sb_s3;
	end

endmodule
`default_nettype wire

>>> rtl/obn_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// One result bit of round(2^F*sqrt(P/Q)): tries setting bit K of m, keeping
// D = P*4^(F+1) - (2m-1)^2*Q and QM = (2m-1)*Q up to date.
module obn_cell #(
	parameter int F   = obn_pkg::FRAC_BITS,
	parameter int K   = 0,
	parameter int QW  = 4 * obn_pkg::IN_WIDTH + 3,
	parameter int DW  = QW + 2 * F + 6,
	parameter int QMW = QW + F + 3
) (
	input  wire                   clk,
	input  wire  signed [DW-1:0]  d_i,
	input  wire  signed [QMW-1:0] qm_i,
	input  wire         [QW-1:0]  q_i,
	input  wire         [F:0]     m_i,
	output logic signed [DW-1:0]  d_o,
	output logic signed [QMW-1:0] qm_o,
	output logic        [QW-1:0]  q_o,
	output logic        [F:0]     m_o
);

	localparam logic [F:0] BIT_K = (F+1)'(1) << K;

	logic signed [DW-1:0] trial;
	logic                 ok;

	always_comb begin
		trial = d_i - (DW'(qm_i) <<< (K + 2)) - $signed(DW'(q_i) << (2 * K + 2));
		ok    = ~trial[DW-1];
	end

	always_ff @(posedge clk) begin
		d_o  <= ok ? trial : d_i;
		qm_o <= ok ? (qm_i + $signed(QMW'(q_i) << (K + 1))) : qm_i;
		q_o  <= q_i;
		m_o  <= ok ? (m_i | BIT_K) : m_i;
	end

endmodule
`default_nettype wire

>>> rtl/obn_root.sv
`timescale 1ns / 1ps
`default_nettype none
// Entry stage plus a row of F+1 cells, most significant bit first.
module obn_root #(
	parameter int F  = obn_pkg::FRAC_BITS,
	parameter int PW = 4 * obn_pkg::IN_WIDTH,
	parameter int QW = 4 * obn_pkg::IN_WIDTH + 3
) (
	input  wire           clk,
	input  wire  [PW-1:0] p,
	input  wire  [QW-1:0] q,
	output logic [F:0]    m
);

	localparam int DW  = QW + 2 * F + 6;
	localparam int QMW = QW + F + 3;

	logic signed [DW-1:0]  d_c  [F+2];
	logic signed [QMW-1:0] qm_c [F+2];
	logic        [QW-1:0]  q_c  [F+2];
	logic        [F:0]     m_c  [F+2];

	// m = 0 to start: (2m-1)^2 = 1
	always_ff @(posedge clk) begin
		d_c[0]  <= $signed(DW'(p) << (2 * F + 2)) - $signed(DW'(q));
		qm_c[0] <= -$signed(QMW'(q));
		q_c[0]  <= q;
		m_c[0]  <= '0;
	end

	for (genvar i = 0; i <= F; i++) begin : g_cell
		obn_cell #(
			.F  (F),
			.K  (F - i),
			.QW (QW),
			.DW (DW),
			.QMW(QMW)
		) u_cell (
			.clk (clk),
			.d_i (d_c[i]),
			.qm_i(qm_c[i]),
			.q_i (q_c[i]),
			.m_i (m_c[i]),
			.d_o (d_c[i+1]),
			.qm_o(qm_c[i+1]),
			.q_o (q_c[i+1]),
			.m_o (m_c[i+1])
		);
	end

	assign m = m_c[F+1];

endmodule
`default_nettype wire

>>> rtl/orthonormal_basis_from_normal_top.sv
`timescale 1ns / 1ps
`default_nettype none
// channel   ports                    handshake
// ------    -----------------------  --------------------------------------
// normal    normal (normal_t)        word taken when start && !busy
// basis     basis (basis_t)          word valid for the one cycle done is high
//
// One word per cycle; busy is never raised.
// From start to done: four preparation stages (squares, norms, split 33x17
// and 32x16 products, sums), one entry stage, one cell per result bit of the
// shared-denominator square roots, one output register.
// arst_n clears only the valid pipeline; data registers are not reset.
// The receiver cannot stall: each basis word is held for a single cycle.
module orthonormal_basis_from_normal_top #(
	parameter int IN_WIDTH  = obn_pkg::IN_WIDTH,
	parameter int FRAC_BITS = obn_pkg::FRAC_BITS
) (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              start,
	output logic             busy,
	input  obn_pkg::normal_t normal,
	output logic             done,
	output obn_pkg::basis_t  basis
);

	localparam int PW  = 4 * IN_WIDTH;
	localparam int QW  = 4 * IN_WIDTH + 3;
	localparam int OW  = FRAC_BITS + 2;
	localparam int LAT = FRAC_BITS + 7;
	localparam int NL  = obn_pkg::NUM_LANES;

	logic [PW-1:0] p_s4 [NL];
	logic [QW-1:0] q_s4 [NL];
	logic [FRAC_BITS:0] m_lane [NL];
	obn_pkg::sideband_t sb_s4;
	obn_pkg::sideband_t sb_q [FRAC_BITS+2];
	logic [LAT-1:0] vld_q;
	logic signed [OW-1:0] f_c [NL];
	obn_pkg::basis_t basis_q;

	assign busy = 1'b0;

	obn_prep #(
		.W (IN_WIDTH),
		.PW(PW),
		.QW(QW)
	) u_prep (
		.clk  (clk),
		.in_x (IN_WIDTH'(normal.normal_x)),
		.in_y (IN_WIDTH'(normal.normal_y)),
		.in_z (IN_WIDTH'(normal.normal_z)),
		.p_s4 (p_s4),
		.q_s4 (q_s4),
		.sb_s4(sb_s4)
	);

	for (genvar l = 0; l < NL; l++) begin : g_lane
		obn_root #(
			.F (FRAC_BITS),
			.PW(PW),
			.QW(QW)
		) u_root (
			.clk(clk),
			.p  (p_s4[l]),
			.q  (q_s4[l]),
			.m  (m_lane[l])
		);
		always_comb begin
			if (sb_q[FRAC_BITS+1].zero) begin
				f_c[l] = '0;
			end else if (sb_q[FRAC_BITS+1].neg[l]) begin
				f_c[l] = -$signed(OW'(m_lane[l]));
			end else begin
				f_c[l] = $signed(OW'(m_lane[l]));
			end
		end
	end

	always_ff @(posedge clk) begin
		sb_q[0] <= sb_s4;
		for (int i = 1; i < FRAC_BITS + 2; i++) begin
			sb_q[i] <= sb_q[i-1];
		end
		basis_q.u_x        <= obn_pkg::OUT_WIDTH'(f_c[obn_pkg::LANE_UX]);
		basis_q.u_y        <= obn_pkg::OUT_WIDTH'(f_c[obn_pkg::LANE_UY]);
		basis_q.u_z        <= obn_pkg::OUT_WIDTH'(f_c[obn_pkg::LANE_UZ]);
		basis_q.v_x        <= obn_pkg::OUT_WIDTH'(f_c[obn_pkg::LANE_VX]);
		basis_q.v_y        <= obn_pkg::OUT_WIDTH'(f_c[obn_pkg::LANE_VY]);
		basis_q.v_z        <= obn_pkg::OUT_WIDTH'(f_c[obn_pkg::LANE_VZ]);
		basis_q.w_x        <= obn_pkg::OUT_WIDTH'(f_c[obn_pkg::LANE_WX]);
		basis_q.w_y        <= obn_pkg::OUT_WIDTH'(f_c[obn_pkg::LANE_WY]);
		basis_q.w_z        <= obn_pkg::OUT_WIDTH'(f_c[obn_pkg::LANE_WZ]);
		basis_q.major_axis <= sb_q[FRAC_BITS+1].axis;
		basis_q.degenerate <= sb_q[FRAC_BITS+1].zero;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[LAT-2:0], start & ~busy};
		end
	end

	assign done  = vld_q[LAT-1];
	assign basis = basis_q;

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##LAT done)
		else $error("word lost in pipeline");

	a_degenerate: assert property (@(posedge clk) disable iff (!arst_n)
		done && basis.degenerate |-> basis.w_x == 0 && basis.u_y == 0 &&
		basis.v_z == 0 && basis.major_axis == obn_pkg::AXIS_X)
		else $error("zero normal gave non-zero basis");

	a_unit_w: assert property (@(posedge clk) disable iff (!arst_n)
		done && !basis.degenerate |-> basis.w_x != 0 || basis.w_y != 0 || basis.w_z != 0)
		else $error("unit normal came out zero");

endmodule
`default_nettype wire

>>> sim/orthonormal_basis_from_normal_top_tb.sv
`timescale 1ns / 1ps
module orthonormal_basis_from_normal_top_tb;

	localparam int LATENCY = obn_pkg::FRAC_BITS + 7;

	logic             clk;
	logic             arst_n;
	logic             start;
	logic             busy;
	obn_pkg::normal_t normal;
	logic             done;
	obn_pkg::basis_t  basis;

	obn_pkg::basis_t  pending_bases[$];
	int               mismatches;

	orthonormal_basis_from_normal_top u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.normal (normal),
		.done   (done),
		.basis  (basis)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("*** FAILED ***");
		$finish;
	end

	// round(2^FRAC_BITS * mag / sqrt(den)), signed by neg
	function automatic logic [obn_pkg::OUT_WIDTH-1:0] unit_component(logic [63:0] mag,
			bit neg, logic [127:0] den);
		logic [127:0] lim;
		logic [127:0] odd;
		logic [127:0] prod;
		longint unsigned lo, hi, mid;
		logic [obn_pkg::OUT_WIDTH-1:0] r;
		lim = {64'b0, mag};
		lim = (lim * lim) << (2 * obn_pkg::FRAC_BITS + 2);
		lo = 0;
		hi = longint'(1) << obn_pkg::FRAC_BITS;
		while (lo < hi) begin
			mid = (lo + hi + 1) / 2;
			odd = 128'(2 * mid - 1);
			prod = odd * odd * den;
			if (prod <= lim)
				lo = mid;
			else
				hi = mid - 1;
		end
		r = lo[obn_pkg::OUT_WIDTH-1:0];
		return neg ? -r : r;
	endfunction

	function automatic obn_pkg::basis_t predict_basis(obn_pkg::normal_t n);
		obn_pkg::basis_t b;
		longint x, y, z;
		logic [63:0] ax, ay, az, best, s, t2;
		logic [127:0] qs, qt, qu;
		x = n.normal_x;
		y = n.normal_y;
		z = n.normal_z;
		ax = x < 0 ? -x : x;
		ay = y < 0 ? -y : y;
		az = z < 0 ? -z : z;
		b = '0;
		b.major_axis = obn_pkg::AXIS_X;
		best = ax;
		if (ay > best) begin
			b.major_axis = obn_pkg::AXIS_Y;
			best = ay;
		end
		if (az > best)
			b.major_axis = obn_pkg::AXIS_Z;
		if (ax == 0 && ay == 0 && az == 0) begin
			b = '0;
			b.degenerate = 1'b1;
			return b;
		end
		s = ax * ax + ay * ay + az * az;
		qs = {64'b0, s};
		b.w_x = unit_component(ax, x < 0, qs);
		b.w_y = unit_component(ay, y < 0, qs);
		b.w_z = unit_component(az, z < 0, qs);
		if (b.major_axis != obn_pkg::AXIS_X) begin
			t2 = ay * ay + az * az;
			qt = {64'b0, t2};
			qu = qt * {64'b0, s};
			b.v_x = '0;
			b.v_y = unit_component(az, z < 0, qt);
			b.v_z = unit_component(ay, y > 0, qt);
			b.u_x = unit_component(t2, 1'b0, qu);
			b.u_y = unit_component(ax * ay, (x < 0) == (y < 0), qu);
			b.u_z = unit_component(ax * az, (x < 0) == (z < 0), qu);
		end else begin
			t2 = ax * ax + az * az;
			qt = {64'b0, t2};
			qu = qt * {64'b0, s};
			b.v_x = unit_component(az, z > 0, qt);
			b.v_y = '0;
			b.v_z = unit_component(ax, x < 0, qt);
			b.u_x = unit_component(ax * ay, (x < 0) == (y < 0), qu);
			b.u_y = unit_component(t2, 1'b0, qu);
			b.u_z = unit_component(ay * az, (y < 0) == (z < 0), qu);
		end
		return b;
	endfunction

	task automatic check_field(string name, int expv, int gotv);
		if (expv != gotv) begin
			mismatches++;
			$display("%0t: %s expected %0d got %0d", $time, name, expv, gotv);
		end
	endtask

	always @(posedge clk) begin
		obn_pkg::basis_t e;
		if (arst_n && done) begin
			if (pending_bases.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected word, expected none got %p", $time, basis);
			end else begin
				e = pending_bases.pop_front();
				check_field("u_x", e.u_x, basis.u_x);
				check_field("u_y", e.u_y, basis.u_y);
				check_field("u_z", e.u_z, basis.u_z);
				check_field("v_x", e.v_x, basis.v_x);
				check_field("v_y", e.v_y, basis.v_y);
				check_field("v_z", e.v_z, basis.v_z);
				check_field("w_x", e.w_x, basis.w_x);
				check_field("w_y", e.w_y, basis.w_y);
				check_field("w_z", e.w_z, basis.w_z);
				check_field("major_axis", e.major_axis, basis.major_axis);
				check_field("degenerate", e.degenerate, basis.degenerate);
			end
		end
	end

	int idle_pct;

	// called at a falling edge; returns at the falling edge after acceptance
	task automatic send_normal(int x, int y, int z);
		obn_pkg::normal_t n;
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		n.normal_x = x[obn_pkg::IN_WIDTH-1:0];
		n.normal_y = y[obn_pkg::IN_WIDTH-1:0];
		n.normal_z = z[obn_pkg::IN_WIDTH-1:0];
		start <= 1'b1;
		normal <= n;
		forever begin
			@(posedge clk);
			if (!busy)
				break;
		end
		pending_bases.push_back(predict_basis(n));
		@(negedge clk);
	endtask

	task automatic wait_drained();
		start <= 1'b0;
		while (pending_bases.size() != 0)
			@(negedge clk);
	endtask

	task automatic test_directed();
		idle_pct = 0;
		send_normal(0, 0, 0);
		send_normal(-32768, 0, 0);
		send_normal(0, -32768, 0);
		send_normal(0, 0, -32768);
		send_normal(32767, 0, 0);
		send_normal(0, 32767, 0);
		send_normal(0, 0, 32767);
		send_normal(-32768, -32768, -32768);
		send_normal(32767, 32767, 32767);
		send_normal(5, -5, 3);      // x/y tie goes to x
		send_normal(1, 7, -7);      // y/z tie goes to y
		send_normal(-4, 2, 4);      // x/z tie goes to x
		send_normal(1, 1, 1);
		send_normal(-1, 0, 0);
		send_normal(0, 1, 0);
		send_normal(0, 0, -1);
		send_normal(3, 4, 0);
		send_normal(-32768, 32767, -1);
		send_normal(1, -32768, 32767);
		send_normal(2, 2, 1);
		wait_drained();
	endtask

	task automatic test_random(int pct, int count);
		int x, y, z, m;
		idle_pct = pct;
		repeat (count) begin
			case ($urandom_range(3))
				0: begin
					x = $urandom;
					y = $urandom;
					z = $urandom;
				end
				1: begin
					x = int'($urandom_range(16)) - 8;
					y = int'($urandom_range(16)) - 8;
					z = int'($urandom_range(16)) - 8;
				end
				2: begin
					// magnitude ties between x and y, and sometimes z
					m = $urandom_range(32768);
					x = $urandom_range(1) ? m : -m;
					y = $urandom_range(1) ? m : -m;
					z = $urandom_range(1) ? m : int'($urandom_range(m));
					if ($urandom_range(1))
						x = -x;
				end
				default: begin
					x = int'($urandom_range(1)) << $urandom_range(15);
					y = -(int'($urandom_range(1)) << $urandom_range(15));
					z = $urandom_range(1) ? int'($urandom) : 0;
				end
			endcase
			send_normal(x, y, z);
		end
	endtask

	// sender holds off until the pipeline has emptied
	task automatic test_pause_for_drain();
		test_random(0, 30);
		wait_drained();
		test_random(0, 30);
	endtask

	initial begin
		int guard;
		mismatches = 0;
		idle_pct = 0;
		start = 1'b0;
		normal = '0;
		arst_n = 1'b0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		test_random(0, 150);
		test_random(63, 150);
		test_pause_for_drain();
		test_random(11, 150);
		test_random(0, 60);
		start <= 1'b0;
		guard = 0;
		while (pending_bases.size() != 0 && guard < 10 * LATENCY + 1000) begin
			@(negedge clk);
			guard++;
		end
		repeat (2 * LATENCY) @(negedge clk);
		if (mismatches == 0 && pending_bases.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
